// ===== src/tsnm_pkg.sv =====
package tsnm_pkg;

  localparam int COMPONENT_BITS_DEF = 16;

  // normalised magnitude width; the largest magnitude lands in [2^29, 2^30)
  localparam int NORM_BITS  = 30;
  localparam int SUM_BITS   = 2 * NORM_BITS + 2;
  localparam int SQRT_STEPS = SUM_BITS / 2;

  // shift/square/sum front end, root bits, numerator prep, quotient bits, output
  function automatic int norm_latency(input int frac);
    return 5 + SQRT_STEPS + 1 + (frac + 2) + 1;
  endfunction

endpackage

// ===== src/tsnm_dly.sv =====
module tsnm_dly #(
  parameter int WID = 1,
  parameter int DEP = 1
) (
  input  logic           clk_i,
  input  logic [WID-1:0] d_i,
  output logic [WID-1:0] q_o
);

  logic [WID-1:0] sr_q [DEP];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < DEP; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[DEP-1];

endmodule

// ===== src/tsnm_norm3.sv =====
module tsnm_norm3 import tsnm_pkg::*; #(
  parameter int VW = 16,
  parameter int FR = 14
) (
  input  logic                 clk_i,
  input  logic signed [VW-1:0] v_i [3],
  output logic signed [FR+1:0] u_o [3],
  output logic                 nz_o
);

  localparam int SW = VW + NORM_BITS - 1;
  localparam int PB = $clog2(VW);
  localparam int QW = FR + 2;
  localparam int NW = NORM_BITS + FR + 1;
  localparam int RW = SQRT_STEPS + 2;
  localparam int LW = SQRT_STEPS;

  // magnitudes and leading-one search
  logic [VW-1:0]        mag1_d [3];
  logic [VW-1:0]        mag1_q [3];
  logic [2:0]           sgn1_q;
  logic [VW-1:0]        or1_q;
  logic [VW-1:0]        mag2_q [3];
  logic [2:0]           sgn2_q;
  logic [PB-1:0]        pos2_d;
  logic [PB-1:0]        pos2_q;
  logic                 nz2_q;
  logic [NORM_BITS-1:0] m3_q [3];
  logic [2:0]           sgn3_q;
  logic                 nz3_q;
  logic [2*NORM_BITS-1:0] sq4_q [3];
  logic [NORM_BITS-1:0] m4_q [3];
  logic [2:0]           sgn4_q;
  logic                 nz4_q;

  // root pipeline
  logic [SUM_BITS-1:0]  rem_q  [SQRT_STEPS+1];
  logic [LW-1:0]        root_q [SQRT_STEPS+1];
  logic [NORM_BITS-1:0] ms_q   [SQRT_STEPS+1][3];
  logic [2:0]           sgns_q [SQRT_STEPS+1];
  logic                 nzs_q  [SQRT_STEPS+1];
  logic [SUM_BITS:0]    cand   [SQRT_STEPS];

  // quotient pipeline
  logic [RW-1:0]        dr_q   [QW+1][3];
  logic [QW-1:0]        dlo_q  [QW+1][3];
  logic [QW-1:0]        dq_q   [QW+1][3];
  logic [LW-1:0]        dl_q   [QW+1];
  logic [2:0]           sgnd_q [QW+1];
  logic                 nzd_q  [QW+1];
  logic [RW-1:0]        dr_d   [QW][3];
  logic [QW-1:0]        dq_d   [QW][3];
  logic [NW-1:0]        num    [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag1_d[j] = v_i[j][VW-1] ? $unsigned(-v_i[j]) : $unsigned(v_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      mag1_q[j] <= mag1_d[j];
      sgn1_q[j] <= v_i[j][VW-1];
    end
    or1_q <= mag1_d[0] | mag1_d[1] | mag1_d[2];
  end

  always_comb begin
    pos2_d = '0;
    for (int k = 0; k < VW; k++) begin
      if (or1_q[k]) begin
        pos2_d = PB'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag2_q <= mag1_q;
    sgn2_q <= sgn1_q;
    pos2_q <= pos2_d;
    nz2_q  <= |or1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      m3_q[j] <= NORM_BITS'((SW'(mag2_q[j]) << (NORM_BITS - 1)) >> pos2_q);
    end
    sgn3_q <= sgn2_q;
    nz3_q  <= nz2_q;
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      sq4_q[j] <= (2*NORM_BITS)'(m3_q[j]) * (2*NORM_BITS)'(m3_q[j]);
    end
    m4_q   <= m3_q;
    sgn4_q <= sgn3_q;
    nz4_q  <= nz3_q;
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= SUM_BITS'(sq4_q[0]) + SUM_BITS'(sq4_q[1]) + SUM_BITS'(sq4_q[2]);
    root_q[0] <= '0;
    ms_q[0]   <= m4_q;
    sgns_q[0] <= sgn4_q;
    nzs_q[0]  <= nz4_q;
  end

  // one root bit per stage, msb first
  always_comb begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      cand[i] = ((SUM_BITS+1)'(root_q[i]) << (SQRT_STEPS - i))
              + ((SUM_BITS+1)'(1) << (2 * (SQRT_STEPS - 1 - i)));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      if ((SUM_BITS+1)'(rem_q[i]) >= cand[i]) begin
        rem_q[i+1]  <= SUM_BITS'((SUM_BITS+1)'(rem_q[i]) - cand[i]);
        root_q[i+1] <= root_q[i] | (LW'(1) << (SQRT_STEPS - 1 - i));
      end else begin
        rem_q[i+1]  <= rem_q[i];
        root_q[i+1] <= root_q[i];
      end
      ms_q[i+1]   <= ms_q[i];
      sgns_q[i+1] <= sgns_q[i];
      nzs_q[i+1]  <= nzs_q[i];
    end
  end

  // numerator m*2^F + L/2
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = (NW'(ms_q[SQRT_STEPS][j]) << FR) + NW'(root_q[SQRT_STEPS] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      dr_q[0][j]  <= RW'(num[j] >> QW);
      dlo_q[0][j] <= num[j][QW-1:0];
      dq_q[0][j]  <= '0;
    end
    dl_q[0]   <= root_q[SQRT_STEPS];
    sgnd_q[0] <= sgns_q[SQRT_STEPS];
    nzd_q[0]  <= nzs_q[SQRT_STEPS];
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [RW:0] tr;
    logic        ge;
    for (int i = 0; i < QW; i++) begin
      for (int j = 0; j < 3; j++) begin
        tr = {dr_q[i][j], dlo_q[i][j][QW-1-i]};
        ge = tr >= (RW+1)'(dl_q[i]);
        dr_d[i][j] = ge ? RW'(tr - (RW+1)'(dl_q[i])) : RW'(tr);
        dq_d[i][j] = {dq_q[i][j][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QW; i++) begin
      dr_q[i+1]   <= dr_d[i];
      dq_q[i+1]   <= dq_d[i];
      dlo_q[i+1]  <= dlo_q[i];
      dl_q[i+1]   <= dl_q[i];
      sgnd_q[i+1] <= sgnd_q[i];
      nzd_q[i+1]  <= nzd_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (!nzd_q[QW]) begin
        u_o[j] <= '0;
      end else if (sgnd_q[QW][j]) begin
        u_o[j] <= -$signed(dq_q[QW][j]);
      end else begin
        u_o[j] <= $signed(dq_q[QW][j]);
      end
    end
    nz_o <= nzd_q[QW];
  end

endmodule

// ===== src/tangent_space_normal_map.sv =====
// Channel | Ports                                     | Handshake
// input   | start_i, busy_o, eight field ports        | word taken when start_i high, busy_o low
// result  | done_o, mapped/unit_normal_o, degenerate_o | word valid for this one cycle only
// One fragment per clock; busy_o is tied low. The path runs through the three
// chained normalisers (root, one bit a stage, then a quotient bit a stage).
// Reset clears only the valid chain; data stages are not reset. The receiver
// cannot stall, so the pipeline never holds.
module tangent_space_normal_map import tsnm_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [47:0] vertex0_pos_i,
  input  logic [47:0] vertex1_pos_i,
  input  logic [47:0] vertex2_pos_i,
  input  logic [31:0] tex_coord0_i,
  input  logic [31:0] tex_coord1_i,
  input  logic [31:0] tex_coord2_i,
  input  logic [47:0] surface_normal_i,
  input  logic [23:0] texel_color_i,
  output logic        done_o,
  output logic [47:0] mapped_normal_o,
  output logic [47:0] unit_normal_o,
  output logic        degenerate_o
);

  localparam int W    = COMPONENT_BITS;
  localparam int F    = W - 2;
  localparam int W2   = 2 * W;
  localparam int W3   = 3 * W;
  localparam int DW   = W + 1;
  localparam int PW2  = 2 * W + 2;
  localparam int TRW  = 2 * W + 3;
  localparam int TW   = 2 * W + 4;
  localparam int GW   = W + 2;
  localparam int QPW  = GW + W;
  localparam int RW   = 2 * W + 6;
  localparam int LU   = norm_latency(F);
  localparam int TOT  = 14 + 3 * LU;
  localparam logic signed [RW-1:0] SMAX = RW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

  typedef logic signed [W-1:0] tex_lut_t [256];

  function automatic tex_lut_t tex_lut_build();
    tex_lut_t lut;
    longint   num;
    longint   mag;
    longint   q;
    for (int c = 0; c < 256; c++) begin
      num = 2 * c - 255;
      mag = (num < 0) ? -num : num;
      q   = ((mag <<< F) + 127) / 255;
      lut[c] = W'((num < 0) ? -q : q);
    end
    return lut;
  endfunction

  localparam tex_lut_t TEX_LUT = tex_lut_build();

  // shift right by F, half away from zero
  function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] x);
    logic signed [RW-1:0] h;
    h = RW'(1) <<< (F - 1);
    if (x >= 0) begin
      return (x + h) >>> F;
    end
    return -((-x + h) >>> F);
  endfunction

  logic [TOT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOT-2:0], start_i && !busy_o};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[TOT-1];

  // ---- P1: unpack, differences, texel mapping
  logic [W3-1:0] p0w, p1w, p2w, nw;
  logic [W2-1:0] c0w, c1w, c2w;
  logic signed [W-1:0] p0c [3], p1c [3], p2c [3], nrc [3];
  logic signed [DW-1:0] e1_q [3], e2_q [3];
  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [W-1:0] nr1_q [3], s1_q [3];

  assign p0w = W3'(vertex0_pos_i);
  assign p1w = W3'(vertex1_pos_i);
  assign p2w = W3'(vertex2_pos_i);
  assign nw  = W3'(surface_normal_i);
  assign c0w = W2'(tex_coord0_i);
  assign c1w = W2'(tex_coord1_i);
  assign c2w = W2'(tex_coord2_i);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0c[i] = $signed(p0w[i*W +: W]);
      p1c[i] = $signed(p1w[i*W +: W]);
      p2c[i] = $signed(p2w[i*W +: W]);
      nrc[i] = $signed(nw[i*W +: W]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e1_q[i]  <= DW'(p2c[i]) - DW'(p0c[i]);
      e2_q[i]  <= DW'(p1c[i]) - DW'(p0c[i]);
      nr1_q[i] <= nrc[i];
    end
    du1_q <= DW'($signed(c2w[0 +: W])) - DW'($signed(c0w[0 +: W]));
    dv1_q <= DW'($signed(c2w[W +: W])) - DW'($signed(c0w[W +: W]));
    du2_q <= DW'($signed(c1w[0 +: W])) - DW'($signed(c0w[0 +: W]));
    dv2_q <= DW'($signed(c1w[W +: W])) - DW'($signed(c0w[W +: W]));
    s1_q[0] <= TEX_LUT[texel_color_i[23:16]];
    s1_q[1] <= TEX_LUT[texel_color_i[15:8]];
    s1_q[2] <= TEX_LUT[texel_color_i[7:0]];
  end

  // ---- P2: products
  logic signed [PW2-1:0] a2_q [3], b2_q [3], c2_q [3], d2_q [3];
  logic signed [PW2-1:0] x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a2_q[i] <= PW2'(dv2_q) * PW2'(e1_q[i]);
      b2_q[i] <= PW2'(dv1_q) * PW2'(e2_q[i]);
      c2_q[i] <= PW2'(du1_q) * PW2'(e2_q[i]);
      d2_q[i] <= PW2'(du2_q) * PW2'(e1_q[i]);
    end
    x2_q <= PW2'(du1_q) * PW2'(dv2_q);
    y2_q <= PW2'(du2_q) * PW2'(dv1_q);
  end

  // ---- P3: raw tangent, bitangent, determinant
  logic signed [TRW-1:0] tr3_q [3], br3_q [3];
  logic signed [TRW-1:0] det3_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tr3_q[i] <= TRW'(a2_q[i]) - TRW'(b2_q[i]);
      br3_q[i] <= TRW'(c2_q[i]) - TRW'(d2_q[i]);
    end
    det3_q <= TRW'(x2_q) - TRW'(y2_q);
  end

  // ---- P4: orientation flip
  logic signed [TW-1:0] tr4_q [3], br4_q [3];
  logic                 ok4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tr4_q[i] <= (det3_q < 0) ? -TW'(tr3_q[i]) : TW'(tr3_q[i]);
      br4_q[i] <= (det3_q < 0) ? -TW'(br3_q[i]) : TW'(br3_q[i]);
    end
    ok4_q <= det3_q != '0;
  end

  logic [2*W3-1:0] ca4;
  logic signed [W-1:0] nr4 [3], s4 [3];

  tsnm_dly #(.WID(2 * W3), .DEP(3)) u_dly_p (
    .clk_i (clk_i),
    .d_i   ({nr1_q[2], nr1_q[1], nr1_q[0], s1_q[2], s1_q[1], s1_q[0]}),
    .q_o   (ca4)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nr4[i] = $signed(ca4[W3 + i*W +: W]);
      s4[i]  = $signed(ca4[i*W +: W]);
    end
  end

  // ---- first normalisers
  logic signed [W-1:0] n_u [3], t0_u [3], b0_u [3];
  logic nz_n, nz_t0, nz_b0;

  tsnm_norm3 #(.VW(W), .FR(F)) u_norm_n (
    .clk_i (clk_i), .v_i (nr4), .u_o (n_u), .nz_o (nz_n)
  );

  tsnm_norm3 #(.VW(TW), .FR(F)) u_norm_t0 (
    .clk_i (clk_i), .v_i (tr4_q), .u_o (t0_u), .nz_o (nz_t0)
  );

  tsnm_norm3 #(.VW(TW), .FR(F)) u_norm_b0 (
    .clk_i (clk_i), .v_i (br4_q), .u_o (b0_u), .nz_o (nz_b0)
  );

  logic [W3:0] sa;
  logic        ok_a;

  tsnm_dly #(.WID(W3 + 1), .DEP(LU)) u_dly_a (
    .clk_i (clk_i),
    .d_i   ({ok4_q, s4[2], s4[1], s4[0]}),
    .q_o   (sa)
  );

  assign ok_a = sa[W3] & nz_n & nz_t0 & nz_b0;

  // ---- G: tangent against normal
  logic signed [W2-1:0] ptn_q [3], pbn_q [3];
  logic signed [GW-1:0] dtn_q, dbn_q, dbn3_q, dbn4_q;
  logic signed [QPW-1:0] qn_q [3];
  logic signed [GW-1:0] tp_q [3];
  logic [W3-1:0] nd2w, t0d3w;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ptn_q[i] <= W2'(t0_u[i]) * W2'(n_u[i]);
      pbn_q[i] <= W2'(b0_u[i]) * W2'(n_u[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    dtn_q <= GW'(rnd(RW'(ptn_q[0]) + RW'(ptn_q[1]) + RW'(ptn_q[2])));
    dbn_q <= GW'(rnd(RW'(pbn_q[0]) + RW'(pbn_q[1]) + RW'(pbn_q[2])));
  end

  tsnm_dly #(.WID(W3), .DEP(2)) u_dly_n2 (
    .clk_i (clk_i), .d_i ({n_u[2], n_u[1], n_u[0]}), .q_o (nd2w)
  );

  tsnm_dly #(.WID(W3), .DEP(3)) u_dly_t03 (
    .clk_i (clk_i), .d_i ({t0_u[2], t0_u[1], t0_u[0]}), .q_o (t0d3w)
  );

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      qn_q[i] <= QPW'(dtn_q) * QPW'($signed(nd2w[i*W +: W]));
    end
    dbn3_q <= dbn_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tp_q[i] <= GW'($signed(t0d3w[i*W +: W])) - GW'(rnd(RW'(qn_q[i])));
    end
    dbn4_q <= dbn3_q;
  end

  logic [3*W3:0] xa;

  tsnm_dly #(.WID(3 * W3 + 1), .DEP(4)) u_dly_a4 (
    .clk_i (clk_i),
    .d_i   ({b0_u[2], b0_u[1], b0_u[0], n_u[2], n_u[1], n_u[0], ok_a, sa[W3-1:0]}),
    .q_o   (xa)
  );

  // ---- second normaliser
  logic signed [W-1:0] t_u [3];
  logic                nz_t;

  tsnm_norm3 #(.VW(GW), .FR(F)) u_norm_t (
    .clk_i (clk_i), .v_i (tp_q), .u_o (t_u), .nz_o (nz_t)
  );

  logic [3*W3+GW:0] yw;
  logic signed [W-1:0] b0y [3], ny [3], sy [3];
  logic signed [GW-1:0] dbny;
  logic oky;

  tsnm_dly #(.WID(3 * W3 + GW + 1), .DEP(LU)) u_dly_y (
    .clk_i (clk_i), .d_i ({dbn4_q, xa}), .q_o (yw)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b0y[i] = $signed(yw[2*W3 + 1 + i*W +: W]);
      ny[i]  = $signed(yw[W3 + 1 + i*W +: W]);
      sy[i]  = $signed(yw[i*W +: W]);
    end
    oky  = yw[W3];
    dbny = $signed(yw[3*W3 + 1 +: GW]);
  end

  // ---- H: bitangent against normal and tangent
  logic signed [W2-1:0] pbt_q [3];
  logic signed [GW-1:0] dbt_q;
  logic signed [QPW-1:0] q1_q [3], q2_q [3];
  logic signed [GW-1:0] bp_q [3];
  logic [2*W3+GW-1:0] h2w;
  logic [W3-1:0] b0h3w;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pbt_q[i] <= W2'(b0y[i]) * W2'(t_u[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    dbt_q <= GW'(rnd(RW'(pbt_q[0]) + RW'(pbt_q[1]) + RW'(pbt_q[2])));
  end

  tsnm_dly #(.WID(2 * W3 + GW), .DEP(2)) u_dly_h2 (
    .clk_i (clk_i),
    .d_i   ({dbny, ny[2], ny[1], ny[0], t_u[2], t_u[1], t_u[0]}),
    .q_o   (h2w)
  );

  tsnm_dly #(.WID(W3), .DEP(3)) u_dly_h3 (
    .clk_i (clk_i), .d_i ({b0y[2], b0y[1], b0y[0]}), .q_o (b0h3w)
  );

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q1_q[i] <= QPW'($signed(h2w[2*W3 +: GW])) * QPW'($signed(h2w[W3 + i*W +: W]));
      q2_q[i] <= QPW'(dbt_q) * QPW'($signed(h2w[i*W +: W]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      bp_q[i] <= GW'($signed(b0h3w[i*W +: W])) - GW'(rnd(RW'(q1_q[i])))
               - GW'(rnd(RW'(q2_q[i])));
    end
  end

  logic [3*W3:0] zw;

  tsnm_dly #(.WID(3 * W3 + 1), .DEP(4 + LU)) u_dly_z (
    .clk_i (clk_i),
    .d_i   ({t_u[2], t_u[1], t_u[0], ny[2], ny[1], ny[0], oky & nz_t,
             sy[2], sy[1], sy[0]}),
    .q_o   (zw)
  );

  // ---- third normaliser
  logic signed [W-1:0] b_u [3];
  logic                nz_b;

  tsnm_norm3 #(.VW(GW), .FR(F)) u_norm_b (
    .clk_i (clk_i), .v_i (bp_q), .u_o (b_u), .nz_o (nz_b)
  );

  // ---- K: T*x + B*y + N*z
  logic signed [W2-1:0] k1_q [3], k2_q [3], k3_q [3];
  logic signed [W-1:0]  nk_q [3];
  logic                 okk_q;
  logic signed [RW-1:0] vsum [3];
  logic signed [W-1:0]  mapped_d [3];
  logic [W3-1:0]        map_q, unit_q;
  logic                 deg_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      k1_q[i] <= W2'($signed(zw[2*W3 + 1 + i*W +: W])) * W2'($signed(zw[0 +: W]));
      k2_q[i] <= W2'(b_u[i]) * W2'($signed(zw[W +: W]));
      k3_q[i] <= W2'($signed(zw[W3 + 1 + i*W +: W])) * W2'($signed(zw[2*W +: W]));
      nk_q[i] <= $signed(zw[W3 + 1 + i*W +: W]);
    end
    okk_q <= zw[W3] & nz_b;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsum[i] = rnd(RW'(k1_q[i]) + RW'(k2_q[i]) + RW'(k3_q[i]));
      if (!okk_q) begin
        mapped_d[i] = '0;
      end else if (vsum[i] > SMAX) begin
        mapped_d[i] = W'(SMAX);
      end else if (vsum[i] < SMIN) begin
        mapped_d[i] = W'(SMIN);
      end else begin
        mapped_d[i] = W'(vsum[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    map_q  <= {mapped_d[2], mapped_d[1], mapped_d[0]};
    unit_q <= {nk_q[2], nk_q[1], nk_q[0]};
    deg_q  <= !okk_q;
  end

  assign mapped_normal_o = 48'(map_q);
  assign unit_normal_o   = 48'(unit_q);
  assign degenerate_o    = deg_q;

endmodule
